// ===== src/hmvn_pkg.sv =====
package hmvn_pkg;

  localparam logic [12:0] GRID_MAX = 13'd4096;

  // pipeline depths, one quotient or root bit per stage
  localparam int LAT_PREP  = 2;
  localparam int UV_Q      = 17;
  localparam int POS_Q     = 23;
  localparam int SLP_Q     = 31;
  localparam int SQRT_N    = 31;
  localparam int NRM_Q     = 15;
  localparam int SLOPE_LAT = LAT_PREP + SLP_Q + 1;
  localparam int NORM_LAT  = 2 + SQRT_N + NRM_Q + 1;
  localparam int LAT       = SLOPE_LAT + NORM_LAT;
  localparam int AXIS_PAD  = LAT - (LAT_PREP + POS_Q + 1);

  localparam logic [30:0] SLOPE_LIMIT = 31'h4000_0000;

  localparam logic [2:0] CFG_GRID_W  = 3'd0;
  localparam logic [2:0] CFG_GRID_D  = 3'd1;
  localparam logic [2:0] CFG_WORLD_X = 3'd2;
  localparam logic [2:0] CFG_WORLD_Z = 3'd3;

  typedef struct packed {
    logic [11:0] span_x;
    logic [11:0] span_z;
    logic [15:0] size_x;
    logic [15:0] size_z;
  } geom_t;

  // grid register to span (samples minus one), clamped to 2..GRID_MAX samples
  function automatic logic [11:0] grid_span(input logic [12:0] g);
    logic [12:0] e;
    if (g < 13'd2) begin
      e = 13'd2;
    end else if (g > GRID_MAX) begin
      e = GRID_MAX;
    end else begin
      e = g;
    end
    return 12'(e - 13'd1);
  endfunction

  function automatic logic [15:0] size_eff(input logic [15:0] s);
    return (s == 16'd0) ? 16'd1 : s;
  endfunction

endpackage

// ===== src/hmvn_axis.sv =====
module hmvn_axis import hmvn_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [11:0] texel_i,
  input  logic [11:0] span_i,
  input  logic [15:0] size_i,
  output logic [16:0] uv_o,
  output logic [23:0] pos_o
);

  logic [11:0] tc;
  logic [12:0] twice;
  logic        lt;
  logic [11:0] tc_q;
  logic [11:0] dmag_q;
  logic        neg_q;

  always_comb begin
    tc    = (texel_i > span_i) ? span_i : texel_i;
    twice = {tc, 1'b0};
    lt    = twice < {1'b0, span_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tc_q   <= tc;
      neg_q  <= lt;
      dmag_q <= lt ? 12'({1'b0, span_i} - twice) : 12'(twice - {1'b0, span_i});
    end
  end

  logic [27:0] prod;
  logic [27:0] unum_q;
  logic [35:0] pnum_q;
  logic        pneg_q;

  assign prod = dmag_q * size_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unum_q <= {tc_q, 16'd0} + 28'(span_i[11:1]);
      pnum_q <= {1'b0, prod, 7'd0} + 36'(span_i[11:1]);
      pneg_q <= neg_q;
    end
  end

  logic [11:0] urem_q [POS_Q];
  logic [16:0] ulo_q  [POS_Q];
  logic [11:0] prem_q [POS_Q];
  logic [22:0] plo_q  [POS_Q];
  logic        sneg_q [POS_Q];

  for (genvar i = 0; i < POS_Q; i++) begin : g_div
    logic [11:0] urem_in;
    logic [16:0] ulo_in;
    logic [11:0] prem_in;
    logic [22:0] plo_in;
    logic        neg_in;
    logic [12:0] utr;
    logic [12:0] ptr;
    logic        uge;
    logic        pge;

    if (i == 0) begin : g_first
      assign urem_in = {1'b0, unum_q[27:17]};
      assign ulo_in  = unum_q[16:0];
      assign prem_in = pnum_q[34:23];
      assign plo_in  = pnum_q[22:0];
      assign neg_in  = pneg_q;
    end else begin : g_next
      assign urem_in = urem_q[i-1];
      assign ulo_in  = ulo_q[i-1];
      assign prem_in = prem_q[i-1];
      assign plo_in  = plo_q[i-1];
      assign neg_in  = sneg_q[i-1];
    end

    always_comb begin
      utr = {urem_in, ulo_in[16]};
      ptr = {prem_in, plo_in[22]};
      uge = utr >= {1'b0, span_i};
      pge = ptr >= {1'b0, span_i};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        // uv needs fewer quotient bits, it just holds afterwards
        if (i < UV_Q) begin
          urem_q[i] <= uge ? 12'(utr - {1'b0, span_i}) : utr[11:0];
          ulo_q[i]  <= {ulo_in[15:0], uge};
        end else begin
          urem_q[i] <= urem_in;
          ulo_q[i]  <= ulo_in;
        end
        prem_q[i] <= pge ? 12'(ptr - {1'b0, span_i}) : ptr[11:0];
        plo_q[i]  <= {plo_in[21:0], pge};
        sneg_q[i] <= neg_in;
      end
    end
  end

  logic [16:0] uvd_q  [AXIS_PAD+1];
  logic [23:0] posd_q [AXIS_PAD+1];
  logic [23:0] pmag;

  assign pmag = {1'b0, plo_q[POS_Q-1]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      uvd_q[0]  <= ulo_q[POS_Q-1];
      posd_q[0] <= sneg_q[POS_Q-1] ? (24'd0 - pmag) : pmag;
      for (int k = 1; k <= AXIS_PAD; k++) begin
        uvd_q[k]  <= uvd_q[k-1];
        posd_q[k] <= posd_q[k-1];
      end
    end
  end

  assign uv_o  = uvd_q[AXIS_PAD];
  assign pos_o = posd_q[AXIS_PAD];

endmodule

// ===== src/hmvn_slope.sv =====
module hmvn_slope import hmvn_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] h_minus_i,
  input  logic [15:0] h_plus_i,
  input  logic [11:0] span_i,
  input  logic [15:0] size_i,
  output logic [30:0] gmag_o,
  output logic        gneg_o
);

  logic [16:0] dh;
  logic [15:0] adh_q;
  logic        neg_q;
  logic [16:0] den;

  assign dh  = {h_plus_i[15], h_plus_i} - {h_minus_i[15], h_minus_i};
  assign den = {size_i, 1'b0};

  // rising height gives a negative slope
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= !dh[16] && (dh != 17'd0);
      adh_q <= dh[16] ? 16'(17'd0 - dh) : dh[15:0];
    end
  end

  logic [27:0] a;
  logic [34:0] num_q;
  logic        nneg_q;

  assign a = adh_q * span_i;

  // (|dh| * span * 64 + s) / (2 s) is the rounded slope, scaled down by 256
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= {1'b0, a, 6'd0} + 35'(size_i);
      nneg_q <= neg_q;
    end
  end

  logic [16:0] rem_q [SLP_Q];
  logic [30:0] lo_q  [SLP_Q];
  logic        sat_q [SLP_Q];
  logic        sgn_q [SLP_Q];

  for (genvar i = 0; i < SLP_Q; i++) begin : g_div
    logic [16:0] rem_in;
    logic [30:0] lo_in;
    logic        sat_in;
    logic        sgn_in;
    logic [17:0] tr;
    logic        ge;

    if (i == 0) begin : g_first
      logic [16:0] top;
      assign top    = {13'd0, num_q[34:31]};
      assign sat_in = top >= den;
      assign rem_in = sat_in ? 17'd0 : top;
      assign lo_in  = num_q[30:0];
      assign sgn_in = nneg_q;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign lo_in  = lo_q[i-1];
      assign sat_in = sat_q[i-1];
      assign sgn_in = sgn_q[i-1];
    end

    always_comb begin
      tr = {rem_in, lo_in[30]};
      ge = tr >= {1'b0, den};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? 17'(tr - {1'b0, den}) : tr[16:0];
        lo_q[i]  <= {lo_in[29:0], ge};
        sat_q[i] <= sat_in;
        sgn_q[i] <= sgn_in;
      end
    end
  end

  logic [30:0] gmag_q;
  logic        gneg_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gmag_q <= (sat_q[SLP_Q-1] || lo_q[SLP_Q-1] > SLOPE_LIMIT) ? SLOPE_LIMIT
                                                                 : lo_q[SLP_Q-1];
      gneg_q <= sgn_q[SLP_Q-1];
    end
  end

  assign gmag_o = gmag_q;
  assign gneg_o = gneg_q;

endmodule

// ===== src/hmvn_norm.sv =====
module hmvn_norm import hmvn_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] gx_mag_i,
  input  logic        gx_neg_i,
  input  logic [30:0] gz_mag_i,
  input  logic        gz_neg_i,
  output logic [15:0] normal_x_o,
  output logic [14:0] normal_y_o,
  output logic [15:0] normal_z_o
);

  logic [61:0] sqx_q, sqz_q;
  logic [30:0] gxa_q, gza_q;
  logic        gxna_q, gzna_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q  <= gx_mag_i * gx_mag_i;
      sqz_q  <= gz_mag_i * gz_mag_i;
      gxa_q  <= gx_mag_i;
      gza_q  <= gz_mag_i;
      gxna_q <= gx_neg_i;
      gzna_q <= gz_neg_i;
    end
  end

  logic [61:0] sum_q;
  logic [30:0] gxb_q, gzb_q;
  logic        gxnb_q, gznb_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q  <= sqx_q + sqz_q + 62'h1000_0000;
      gxb_q  <= gxa_q;
      gzb_q  <= gza_q;
      gxnb_q <= gxna_q;
      gznb_q <= gzna_q;
    end
  end

  // integer square root, one root bit per stage
  logic [31:0] srem_q  [SQRT_N];
  logic [30:0] sroot_q [SQRT_N];
  logic [61:0] sv_q    [SQRT_N];
  logic [30:0] sgx_q   [SQRT_N];
  logic [30:0] sgz_q   [SQRT_N];
  logic        sgxn_q  [SQRT_N];
  logic        sgzn_q  [SQRT_N];

  for (genvar i = 0; i < SQRT_N; i++) begin : g_sqrt
    logic [31:0] rem_in;
    logic [30:0] root_in;
    logic [61:0] v_in;
    logic [30:0] gx_in, gz_in;
    logic        gxn_in, gzn_in;
    logic [33:0] t;
    logic [33:0] trial;
    logic        ge;

    if (i == 0) begin : g_first
      assign rem_in  = 32'd0;
      assign root_in = 31'd0;
      assign v_in    = sum_q;
      assign gx_in   = gxb_q;
      assign gz_in   = gzb_q;
      assign gxn_in  = gxnb_q;
      assign gzn_in  = gznb_q;
    end else begin : g_next
      assign rem_in  = srem_q[i-1];
      assign root_in = sroot_q[i-1];
      assign v_in    = sv_q[i-1];
      assign gx_in   = sgx_q[i-1];
      assign gz_in   = sgz_q[i-1];
      assign gxn_in  = sgxn_q[i-1];
      assign gzn_in  = sgzn_q[i-1];
    end

    always_comb begin
      t     = {rem_in, v_in[61:60]};
      trial = {1'b0, root_in, 2'b01};
      ge    = t >= trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        srem_q[i]  <= ge ? 32'(t - trial) : t[31:0];
        sroot_q[i] <= {root_in[29:0], ge};
        sv_q[i]    <= {v_in[59:0], 2'b00};
        sgx_q[i]   <= gx_in;
        sgz_q[i]   <= gz_in;
        sgxn_q[i]  <= gxn_in;
        sgzn_q[i]  <= gzn_in;
      end
    end
  end

  // three rounded divisions by the length
  logic [30:0] xrem_q [NRM_Q];
  logic [14:0] xlo_q  [NRM_Q];
  logic [30:0] zrem_q [NRM_Q];
  logic [14:0] zlo_q  [NRM_Q];
  logic [30:0] yrem_q [NRM_Q];
  logic [14:0] ylo_q  [NRM_Q];
  logic [30:0] len_q  [NRM_Q];
  logic        dxn_q  [NRM_Q];
  logic        dzn_q  [NRM_Q];

  for (genvar i = 0; i < NRM_Q; i++) begin : g_div
    logic [30:0] xrem_in, zrem_in, yrem_in, len_in;
    logic [14:0] xlo_in, zlo_in, ylo_in;
    logic        xn_in, zn_in;
    logic [31:0] xt, zt, yt;
    logic        xge, zge, yge;

    if (i == 0) begin : g_first
      logic [30:0] len;
      logic [44:0] xnum, znum;
      logic [30:0] ynum;
      assign len     = sroot_q[SQRT_N-1];
      assign xnum    = {sgx_q[SQRT_N-1], 14'd0} + 45'(len[30:1]);
      assign znum    = {sgz_q[SQRT_N-1], 14'd0} + 45'(len[30:1]);
      assign ynum    = 31'h1000_0000 + 31'(len[30:1]);
      assign xrem_in = {1'b0, xnum[44:15]};
      assign xlo_in  = xnum[14:0];
      assign zrem_in = {1'b0, znum[44:15]};
      assign zlo_in  = znum[14:0];
      assign yrem_in = {15'd0, ynum[30:15]};
      assign ylo_in  = ynum[14:0];
      assign len_in  = len;
      assign xn_in   = sgxn_q[SQRT_N-1];
      assign zn_in   = sgzn_q[SQRT_N-1];
    end else begin : g_next
      assign xrem_in = xrem_q[i-1];
      assign xlo_in  = xlo_q[i-1];
      assign zrem_in = zrem_q[i-1];
      assign zlo_in  = zlo_q[i-1];
      assign yrem_in = yrem_q[i-1];
      assign ylo_in  = ylo_q[i-1];
      assign len_in  = len_q[i-1];
      assign xn_in   = dxn_q[i-1];
      assign zn_in   = dzn_q[i-1];
    end

    always_comb begin
      xt  = {xrem_in, xlo_in[14]};
      zt  = {zrem_in, zlo_in[14]};
      yt  = {yrem_in, ylo_in[14]};
      xge = xt >= {1'b0, len_in};
      zge = zt >= {1'b0, len_in};
      yge = yt >= {1'b0, len_in};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        xrem_q[i] <= xge ? 31'(xt - {1'b0, len_in}) : xt[30:0];
        zrem_q[i] <= zge ? 31'(zt - {1'b0, len_in}) : zt[30:0];
        yrem_q[i] <= yge ? 31'(yt - {1'b0, len_in}) : yt[30:0];
        xlo_q[i]  <= {xlo_in[13:0], xge};
        zlo_q[i]  <= {zlo_in[13:0], zge};
        ylo_q[i]  <= {ylo_in[13:0], yge};
        len_q[i]  <= len_in;
        dxn_q[i]  <= xn_in;
        dzn_q[i]  <= zn_in;
      end
    end
  end

  logic [15:0] nx_q, nz_q;
  logic [14:0] ny_q;
  logic [15:0] xm, zm;

  assign xm = {1'b0, xlo_q[NRM_Q-1]};
  assign zm = {1'b0, zlo_q[NRM_Q-1]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q <= dxn_q[NRM_Q-1] ? (16'd0 - xm) : xm;
      nz_q <= dzn_q[NRM_Q-1] ? (16'd0 - zm) : zm;
      ny_q <= ylo_q[NRM_Q-1];
    end
  end

  assign normal_x_o = nx_q;
  assign normal_y_o = ny_q;
  assign normal_z_o = nz_q;

endmodule

// ===== src/heightmap_vertex_normal_generator.sv =====
// heightmap texel to terrain vertex
// s_axis: one texel per beat (coordinates, center height, four clamped neighbors)
// m_axis: one vertex per beat (position, unit normal, uv), same order as input
// cfg: write channel, index selects grid width, grid depth, world size x, world size z;
//   always ready, write only while the pipeline is empty
// pipeline: the bit-per-stage
//   chain of slope divide (31), square root (31) and normal divide (15) plus
//   prep, square, sum and output stages
// throughput: one beat per cycle while the output beat is taken
// reset: pipeline empty, grid 2 x 2, world 256 x 256
// stall: when the output beat is not taken the whole pipeline freezes and
//   s_axis_tready drops; nothing is lost or repeated
module heightmap_vertex_normal_generator import hmvn_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // texel_x, texel_z, height_center, height_left, height_right, height_back,
  // height_front
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v, zero pad
  output logic [151:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  logic [12:0] grid_w_q, grid_d_q;
  logic [15:0] world_x_q, world_z_q;
  geom_t       geom;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q  <= 13'd2;
      grid_d_q  <= 13'd2;
      world_x_q <= 16'd256;
      world_z_q <= 16'd256;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_GRID_W:  grid_w_q  <= cfg_data_i[12:0];
        CFG_GRID_D:  grid_d_q  <= cfg_data_i[12:0];
        CFG_WORLD_X: world_x_q <= cfg_data_i;
        CFG_WORLD_Z: world_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    geom.span_x = grid_span(grid_w_q);
    geom.span_z = grid_span(grid_d_q);
    geom.size_x = size_eff(world_x_q);
    geom.size_z = size_eff(world_z_q);
  end

  logic           en;
  logic [LAT-1:0] vld_q;

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  logic [15:0] hc_q [LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      hc_q[0] <= s_axis_tdata[39:24];
      for (int k = 1; k < LAT; k++) begin
        hc_q[k] <= hc_q[k-1];
      end
    end
  end

  logic [16:0] tex_u, tex_v;
  logic [23:0] pos_x, pos_z;
  logic [30:0] gx_mag, gz_mag;
  logic        gx_neg, gz_neg;
  logic [15:0] normal_x, normal_z;
  logic [14:0] normal_y;

  hmvn_axis u_axis_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .texel_i(s_axis_tdata[11:0]),
    .span_i (geom.span_x),
    .size_i (geom.size_x),
    .uv_o   (tex_u),
    .pos_o  (pos_x)
  );

  hmvn_axis u_axis_z (
    .clk_i  (clk_i),
    .en_i   (en),
    .texel_i(s_axis_tdata[23:12]),
    .span_i (geom.span_z),
    .size_i (geom.size_z),
    .uv_o   (tex_v),
    .pos_o  (pos_z)
  );

  hmvn_slope u_slope_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .h_minus_i(s_axis_tdata[55:40]),
    .h_plus_i (s_axis_tdata[71:56]),
    .span_i   (geom.span_x),
    .size_i   (geom.size_x),
    .gmag_o   (gx_mag),
    .gneg_o   (gx_neg)
  );

  hmvn_slope u_slope_z (
    .clk_i    (clk_i),
    .en_i     (en),
    .h_minus_i(s_axis_tdata[87:72]),
    .h_plus_i (s_axis_tdata[103:88]),
    .span_i   (geom.span_z),
    .size_i   (geom.size_z),
    .gmag_o   (gz_mag),
    .gneg_o   (gz_neg)
  );

  hmvn_norm u_norm (
    .clk_i     (clk_i),
    .en_i      (en),
    .gx_mag_i  (gx_mag),
    .gx_neg_i  (gx_neg),
    .gz_mag_i  (gz_mag),
    .gz_neg_i  (gz_neg),
    .normal_x_o(normal_x),
    .normal_y_o(normal_y),
    .normal_z_o(normal_z)
  );

  assign m_axis_tdata = {7'd0, tex_v, tex_u, normal_z, normal_y, normal_x,
                         pos_z, hc_q[LAT-1], pos_x};

endmodule

// ===== src/hmvn_checker.sv =====
module hmvn_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [151:0] m_axis_tdata,
  input logic         cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config channel not ready");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[151:145] == 7'd0)
    else $error("output pad bits not zero");

  a_ny_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[94:80] <= 15'd16384)
    else $error("normal y above one");

endmodule

bind heightmap_vertex_normal_generator hmvn_checker u_hmvn_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .cfg_ready_o  (cfg_ready_o)
);

// ===== tb/sv/hmvn_vertex_checker.sv =====
`timescale 1ns / 100ps

module hmvn_vertex_checker import hmvn_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  input  logic         s_ready_i,
  input  logic [103:0] s_data_i,
  input  logic         m_valid_i,
  input  logic         m_ready_i,
  input  logic [151:0] m_data_i,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  output int           failures_o,
  output int           pending_o
);

  typedef struct packed {
    logic [16:0] tex_v;
    logic [16:0] tex_u;
    logic [15:0] normal_z;
    logic [14:0] normal_y;
    logic [15:0] normal_x;
    logic [23:0] pos_z;
    logic [15:0] pos_y;
    logic [23:0] pos_x;
  } vertex_t;

  logic [12:0] grid_w, grid_d;
  logic [15:0] world_x, world_z;
  vertex_t     vertex_q[$];

  function automatic longint div_nearest(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > v) bits = bits >> 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v = v - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  function automatic longint eff_grid(logic [12:0] g);
    if (g < 2) return 2;
    if (g > 4096) return 4096;
    return g;
  endfunction

  function automatic longint grad(logic signed [15:0] hm, logic signed [15:0] hp,
                                  longint n, longint s);
    longint g;
    g = div_nearest(-(longint'(hp) - longint'(hm)) * (n - 1) * 16384, 512 * s);
    if (g > (64'sd1 <<< 30)) g = 64'sd1 <<< 30;
    if (g < -(64'sd1 <<< 30)) g = -(64'sd1 <<< 30);
    return g;
  endfunction

  function automatic vertex_t make_vertex(logic [103:0] d);
    vertex_t v;
    longint nw, nd, sx, sz, tx, tz, gx, gz;
    longint unsigned len;
    nw = eff_grid(grid_w);
    nd = eff_grid(grid_d);
    sx = (world_x == 0) ? 1 : world_x;
    sz = (world_z == 0) ? 1 : world_z;
    tx = d[11:0];
    tz = d[23:12];
    // texel past the edge sticks to the last sample
    if (tx > nw - 1) tx = nw - 1;
    if (tz > nd - 1) tz = nd - 1;
    v.tex_u = 17'((tx * 65536 + (nw - 1) / 2) / (nw - 1));
    v.tex_v = 17'((tz * 65536 + (nd - 1) / 2) / (nd - 1));
    v.pos_x = 24'(div_nearest((2 * tx - (nw - 1)) * sx * 128, nw - 1));
    v.pos_z = 24'(div_nearest((2 * tz - (nd - 1)) * sz * 128, nd - 1));
    v.pos_y = d[39:24];
    gx = grad(d[55:40], d[71:56], nw, sx);
    gz = grad(d[87:72], d[103:88], nd, sz);
    len = root_floor(gx * gx + gz * gz + (64'd1 << 28));
    v.normal_x = 16'(div_nearest(gx * 16384, len));
    v.normal_z = 16'(div_nearest(gz * 16384, len));
    v.normal_y = 15'(((64'd1 << 28) + len / 2) / len);
    return v;
  endfunction

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      failures_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t e, a;
    if (!rst_ni) begin
      grid_w <= 13'd2;
      grid_d <= 13'd2;
      world_x <= 16'd256;
      world_z <= 16'd256;
      failures_o = 0;
      vertex_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_GRID_W:  grid_w <= cfg_data_i[12:0];
          CFG_GRID_D:  grid_d <= cfg_data_i[12:0];
          CFG_WORLD_X: world_x <= cfg_data_i;
          CFG_WORLD_Z: world_z <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) vertex_q = {vertex_q, make_vertex(s_data_i)};
      if (m_valid_i && m_ready_i) begin
        a = m_data_i[144:0];
        if (vertex_q.size() == 0) begin
          $error("vertex beat with nothing expected");
          failures_o++;
        end else begin
          e = vertex_q.pop_front();
          check_field("pos_x", e.pos_x, a.pos_x);
          check_field("pos_y", e.pos_y, a.pos_y);
          check_field("pos_z", e.pos_z, a.pos_z);
          check_field("normal_x", e.normal_x, a.normal_x);
          check_field("normal_y", e.normal_y, a.normal_y);
          check_field("normal_z", e.normal_z, a.normal_z);
          check_field("tex_u", e.tex_u, a.tex_u);
          check_field("tex_v", e.tex_v, a.tex_v);
        end
      end
      pending_o = vertex_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_heightmap_vertex_normal_generator.sv =====
`timescale 1ns / 100ps

module tb_heightmap_vertex_normal_generator;
  import hmvn_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 225;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [103:0] s_axis_tdata;
  logic [151:0] m_axis_tdata;
  logic         cfg_valid_i, cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [15:0]  cfg_data_i;
  int           failures, pending;
  int           send_idle_pct, recv_idle_pct;
  logic         hold_req;
  int           hold_cnt, quiet_cnt;
  int           span_x, span_z;

  heightmap_vertex_normal_generator dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  hmvn_vertex_checker checker_i (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .failures_o(failures), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_req && hold_cnt == 0) begin
      hold_cnt <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_texel(logic [11:0] tx, logic [11:0] tz, logic [15:0] hc,
                            logic [15:0] hl, logic [15:0] hr, logic [15:0] hb,
                            logic [15:0] hf);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {hf, hb, hr, hl, hc, tz, tx};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [15:0] near(logic [15:0] c);
    if ($urandom_range(9) < 4) return 16'($urandom);
    return c + 16'(($urandom & ((1 << $urandom_range(12)) - 1)) - (1 << 11));
  endfunction

  task automatic send_random();
    logic [11:0] tx, tz;
    logic [15:0] hc;
    tx = ($urandom_range(9) < 8) ? 12'($urandom_range(span_x)) : 12'($urandom);
    tz = ($urandom_range(9) < 8) ? 12'($urandom_range(span_z)) : 12'($urandom);
    hc = 16'($urandom);
    send_texel(tx, tz, hc, near(hc), near(hc), near(hc), near(hc));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (LAT + 10) @(posedge clk_i);
  endtask

  function automatic int span_of(int g);
    return (g < 2) ? 1 : (g > 4096) ? 4095 : g - 1;
  endfunction

  int grid_w_tab[PHASES]  = '{2, 4096, 0, 8191, 3, 640, 4096, 2};
  int grid_d_tab[PHASES]  = '{2, 4096, 1, 5000, 17, 480, 2, 4096};
  int world_x_tab[PHASES] = '{256, 1, 0, 65535, 100, 1000, 65535, 1};
  int world_z_tab[PHASES] = '{256, 1, 65535, 0, 300, 750, 65535, 65535};

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_GRID_W;
    cfg_data_i = '0;
    hold_req = 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 79;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        send_idle_pct = 79;
        recv_idle_pct = 24;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p > 0) begin
        write_reg(CFG_GRID_W, 16'(grid_w_tab[p]));
        write_reg(CFG_GRID_D, 16'(grid_d_tab[p]));
        write_reg(CFG_WORLD_X, 16'(world_x_tab[p]));
        write_reg(CFG_WORLD_Z, 16'(world_z_tab[p]));
        // index past the register list, must change nothing
        write_reg(3'(CFG_WORLD_Z + p % 4 + 1), 16'($urandom));
      end
      span_x = span_of(grid_w_tab[p]);
      span_z = span_of(grid_d_tab[p]);
      if (p == 0) begin
        send_texel(0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_texel(1, 1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_texel(12'hFFF, 12'hFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_texel(12'hFFF, 0, 16'h1234, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_texel(0, 12'hAAA, 16'hFFFF, 16'h0100, 16'h0000, 16'h0000, 16'h0001);
        send_texel(12'h555, 1, 16'h0001, 16'hFFFF, 16'h0001, 16'h0040, 16'hFFC0);
      end else if (p == 1) begin
        // steepest slopes: both gradients saturate except in the third and fourth texels
        send_texel(0, 0, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_texel(12'hFFF, 12'hFFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_texel(12'h800, 12'h7FF, 16'h0, 16'h0, 16'h7FFF, 16'h0, 16'h0);
        send_texel(12'h7FF, 12'h800, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0001);
        send_texel(1, 12'hFFE, 16'h5555, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
      end
      if (p == 1 || p == 4) begin
        hold_req <= 1'b1;
        @(posedge clk_i);
        hold_req <= 1'b0;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) send_random();
      drain();
    end

    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
